### hdl/odo_pkg.sv
// Shared types and constants for the differential-drive odometry block.
// Used by the interfaces, controller, datapath, arithmetic units and top level.
package odo_pkg;

  localparam logic [63:0] PI_Q24 = 64'd52707179;
  localparam logic [63:0] MICRO = 64'd1000000;
  localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;
  localparam int CordicSteps = 30;
  localparam int CfgIndexW = 2;
  localparam int CfgDataW = 21;

  typedef enum logic [17:0] {
    ST_IDLE = 18'd1,
    ST_P1   = 18'd2,
    ST_DSN  = 18'd4,
    ST_DSD  = 18'd8,
    ST_DSQ  = 18'd16,
    ST_CT   = 18'd32,
    ST_THN  = 18'd64,
    ST_THQ  = 18'd128,
    ST_TBN  = 18'd256,
    ST_TBQ  = 18'd512,
    ST_COR  = 18'd1024,
    ST_DXM  = 18'd2048,
    ST_DYM  = 18'd4096,
    ST_VLM  = 18'd8192,
    ST_VLQ  = 18'd16384,
    ST_WRM  = 18'd32768,
    ST_WRQ  = 18'd65536,
    ST_DONE = 18'd131072
  } state_t;

  typedef enum logic {ALU_MUL, ALU_DIV} alu_op_t;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_CPR    = 2'd0,
    CFG_RADIUS = 2'd1,
    CFG_TRACK  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    state_t step;
    logic   go;
    logic   cap;
    logic   take_in;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic unit_done;
  } dp_stat_t;

  // arctan(2^-i) in units of 2^-32 turn
  function automatic logic [29:0] atan_entry(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

### hdl/odo_if.sv
// Request channels of the odometry block: encoder samples, results, config writes.
// Depends on odo_pkg for the config port widths.
interface odo_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_count;
  logic signed [15:0] right_count;
  logic [19:0]        elapsed_us;
  modport source (output valid, left_count, right_count, elapsed_us, input ready);
  modport sink (input valid, left_count, right_count, elapsed_us, output ready);
endinterface

interface odo_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [15:0]        heading;
  logic signed [31:0] linear_speed;
  logic signed [31:0] turn_rate;
  modport source (output valid, pos_x, pos_y, heading, linear_speed, turn_rate, input ready);
  modport sink (input valid, pos_x, pos_y, heading, linear_speed, turn_rate, output ready);
endinterface

interface odo_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [odo_pkg::CfgIndexW-1:0] index;
  logic [odo_pkg::CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/odo_muldiv.sv
// Shared shift-add multiplier (32 steps) and restoring rounding divider (64 steps).
// Depends on odo_pkg for the operation code.
module odo_muldiv (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  odo_pkg::alu_op_t op,
  input  logic [63:0]      a,
  input  logic [63:0]      b,
  output logic [63:0]      result,
  output logic             done
);

  logic             busy;
  logic [5:0]       cnt;
  odo_pkg::alu_op_t op_r;
  logic [63:0]      opa;
  logic [63:0]      opb;
  logic [63:0]      acc;
  logic [63:0]      rem;
  logic [64:0]      rem_sh;
  logic             fits;

  assign rem_sh = {rem, opa[63]};
  assign fits   = rem_sh >= {1'b0, opb};
  assign result = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= (op == odo_pkg::ALU_MUL) ? 6'd31 : 6'd63;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r <= op;
      acc  <= '0;
      rem  <= '0;
      opb  <= b;
      // bias the numerator by half the divisor to round to nearest
      opa  <= (op == odo_pkg::ALU_MUL) ? a : a + (b >> 1);
    end else if (busy) begin
      unique case (op_r)
        odo_pkg::ALU_MUL: begin
          if (opb[0]) acc <= acc + opa;
          opa <= opa << 1;
          opb <= opb >> 1;
        end
        odo_pkg::ALU_DIV: begin
          if (fits) begin
            rem <= 64'(rem_sh - {1'b0, opb});
            acc <= {acc[62:0], 1'b1};
          end else begin
            rem <= rem_sh[63:0];
            acc <= {acc[62:0], 1'b0};
          end
          opa <= opa << 1;
        end
        default: ;
      endcase
    end
  end

endmodule

### hdl/odo_cordic.sv
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, 30 steps.
// Depends on odo_pkg for the gain and the arctangent table.
module odo_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic signed [27:0] cos_q,
  output logic signed [27:0] sin_q,
  output logic               done
);

  logic               busy;
  logic [4:0]         step;
  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [33:0] z;
  logic               flip;
  logic signed [33:0] z0;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] at;
  logic signed [33:0] xf;
  logic signed [33:0] yf;

  assign z0 = 34'(signed'(angle));
  assign xs = x >>> step;
  assign ys = y >>> step;
  assign at = $signed({4'b0, odo_pkg::atan_entry(step)});
  assign xf = flip ? -x : x;
  assign yf = flip ? -y : y;
  assign cos_q = 28'((xf + 34'sd32) >>> 6);
  assign sin_q = 28'((yf + 34'sd32) >>> 6);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'(odo_pkg::CordicSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= odo_pkg::CORDIC_K_Q30;
      y <= '0;
      // fold the back half-plane onto the front one and negate at the end
      if (z0 > 34'sd1073741824) begin
        z    <= z0 - 34'sd2147483648;
        flip <= 1'b1;
      end else if (z0 < -34'sd1073741824) begin
        z    <= z0 + 34'sd2147483648;
        flip <= 1'b1;
      end else begin
        z    <= z0;
        flip <= 1'b0;
      end
    end else if (busy) begin
      if (!z[33]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

endmodule

### hdl/odo_ctrl.sv
// Step sequencer of the odometry block: input/output requests and unit launches.
// Depends on odo_pkg for the state encoding and the command/status structs.
module odo_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  odo_pkg::dp_stat_t stat,
  output odo_pkg::dp_cmd_t  cmd
);

  odo_pkg::state_t state;
  odo_pkg::state_t state_next;
  odo_pkg::state_t seq_next;
  logic            primed;
  logic            launched;

  assign in_ready = (state == odo_pkg::ST_IDLE);

  always_comb begin
    unique case (state)
      odo_pkg::ST_P1:  seq_next = odo_pkg::ST_DSN;
      odo_pkg::ST_DSN: seq_next = odo_pkg::ST_DSD;
      odo_pkg::ST_DSD: seq_next = odo_pkg::ST_DSQ;
      odo_pkg::ST_DSQ: seq_next = odo_pkg::ST_CT;
      odo_pkg::ST_CT:  seq_next = odo_pkg::ST_THN;
      odo_pkg::ST_THN: seq_next = odo_pkg::ST_THQ;
      odo_pkg::ST_THQ: seq_next = odo_pkg::ST_TBN;
      odo_pkg::ST_TBN: seq_next = odo_pkg::ST_TBQ;
      odo_pkg::ST_TBQ: seq_next = odo_pkg::ST_COR;
      odo_pkg::ST_COR: seq_next = odo_pkg::ST_DXM;
      odo_pkg::ST_DXM: seq_next = odo_pkg::ST_DYM;
      odo_pkg::ST_DYM: seq_next = odo_pkg::ST_VLM;
      odo_pkg::ST_VLM: seq_next = odo_pkg::ST_VLQ;
      odo_pkg::ST_VLQ: seq_next = odo_pkg::ST_WRM;
      odo_pkg::ST_WRM: seq_next = odo_pkg::ST_WRQ;
      odo_pkg::ST_WRQ: seq_next = odo_pkg::ST_DONE;
      default:         seq_next = odo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    state_next   = state;
    cmd.step     = state;
    cmd.go       = 1'b0;
    cmd.cap      = 1'b0;
    cmd.take_in  = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state)
      odo_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          // the first sample only latches the counts
          if (primed) state_next = odo_pkg::ST_P1;
        end
      end
      odo_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = odo_pkg::ST_IDLE;
        end
      end
      default: begin
        if (!launched) begin
          cmd.go = 1'b1;
        end else if (stat.unit_done) begin
          cmd.cap    = 1'b1;
          state_next = seq_next;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= odo_pkg::ST_IDLE;
      primed    <= 1'b0;
      launched  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.take_in) primed <= 1'b1;
      if (cmd.go) launched <= 1'b1;
      else if (cmd.cap) launched <= 1'b0;
      if (cmd.load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

### hdl/odo_datapath.sv
// Odometry datapath: config and pose registers, operand steering, result capture.
// Depends on odo_pkg, odo_muldiv and odo_cordic.
module odo_datapath #(
  parameter int POS_FRAC_BITS = 16,
  parameter int ANGLE_BITS    = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  odo_pkg::dp_cmd_t              cmd,
  output odo_pkg::dp_stat_t             stat,
  input  logic                          cfg_we,
  input  logic [odo_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [odo_pkg::CfgDataW-1:0]  cfg_data,
  input  logic signed [15:0]            left_count,
  input  logic signed [15:0]            right_count,
  input  logic [19:0]                   elapsed_us,
  output logic signed [31:0]            pos_x,
  output logic signed [31:0]            pos_y,
  output logic [15:0]                   heading,
  output logic signed [31:0]            linear_speed,
  output logic signed [31:0]            turn_rate
);

  localparam int DenShift = 26 - POS_FRAC_BITS;
  localparam int ThrShift = 25 - POS_FRAC_BITS;
  localparam logic [63:0] DsK = odo_pkg::MICRO << DenShift;

  logic [15:0]            cpr;
  logic [19:0]            rad;
  logic [20:0]            trk;
  logic [15:0]            last_left;
  logic [15:0]            last_right;
  logic signed [17:0]     sum_r;
  logic signed [17:0]     dd_r;
  logic [19:0]            us_r;
  logic [63:0]            p1;
  logic [63:0]            den;
  logic [63:0]            ct;
  logic [63:0]            wk;
  logic signed [63:0]     ds;
  logic signed [63:0]     dthr;
  logic signed [63:0]     dthb;
  logic signed [27:0]     cos_r;
  logic signed [27:0]     sin_r;
  logic [ANGLE_BITS-1:0]  acc_hd;
  logic signed [31:0]     acc_x;
  logic signed [31:0]     acc_y;
  logic signed [31:0]     lin;
  logic signed [31:0]     turn;

  logic signed [15:0]     dl;
  logic signed [15:0]     dr;
  logic [15:0]            cpr_eff;
  logic [20:0]            trk_eff;
  logic [17:0]            sum_mag;
  logic [17:0]            dd_mag;
  logic [63:0]            ds_mag;
  logic [63:0]            dthr_mag;
  logic [63:0]            dthb_mag;
  logic [63:0]            dsc_mag;
  logic [27:0]            cos_mag;
  logic [27:0]            sin_mag;
  logic [63:0]            half;
  logic [ANGLE_BITS-1:0]  mid;
  logic [15:0]            hd16;

  odo_pkg::alu_op_t       alu_op;
  logic [63:0]            alu_a;
  logic [63:0]            alu_b;
  logic [63:0]            alu_res;
  logic                   alu_done;
  logic                   alu_start;
  logic                   cor_start;
  logic                   cor_done;
  logic signed [27:0]     cor_c;
  logic signed [27:0]     cor_s;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

  function automatic logic signed [31:0] pos_step(input logic signed [31:0] acc,
                                                  input logic [63:0] mag, input logic neg);
    logic signed [63:0] prod;
    logic signed [63:0] inc;
    prod = neg ? -$signed(mag) : $signed(mag);
    inc  = (prod + 64'sd8388608) >>> 24;
    return sat32(64'(acc) + inc);
  endfunction

  function automatic logic signed [31:0] speed(input logic signed [63:0] v,
                                               input logic [63:0] vmag,
                                               input logic [63:0] q, input logic [19:0] us);
    logic signed [31:0] r;
    if (us == 20'd0) r = '0;
    else if (vmag >= 64'h100_0000_0000) r = v[63] ? 32'sh80000000 : 32'sh7fffffff;
    else r = sat32(v[63] ? -$signed(q) : $signed(q));
    return r;
  endfunction

  assign dl       = signed'(16'(left_count - last_left));
  assign dr       = signed'(16'(right_count - last_right));
  assign cpr_eff  = (cpr == 16'd0) ? 16'd1 : cpr;
  assign trk_eff  = (trk == 21'd0) ? 21'd1 : trk;
  assign sum_mag  = sum_r[17] ? 18'(-sum_r) : 18'(sum_r);
  assign dd_mag   = dd_r[17] ? 18'(-dd_r) : 18'(dd_r);
  assign ds_mag   = ds[63] ? 64'(-ds) : 64'(ds);
  assign dthr_mag = dthr[63] ? 64'(-dthr) : 64'(dthr);
  assign dthb_mag = dthb[63] ? 64'(-dthb) : 64'(dthb);
  // clamp the step length before the position update
  assign dsc_mag  = (ds_mag > 64'h40_0000_0000) ? 64'h40_0000_0000 : ds_mag;
  assign cos_mag  = cos_r[27] ? 28'(-cos_r) : 28'(cos_r);
  assign sin_mag  = sin_r[27] ? 28'(-sin_r) : 28'(sin_r);
  assign half     = dthb_mag >> 1;
  assign mid      = dthb[63] ? acc_hd - half[ANGLE_BITS-1:0] : acc_hd + half[ANGLE_BITS-1:0];

  generate
    if (ANGLE_BITS >= 16) begin : g_hd_wide
      assign hd16 = acc_hd[ANGLE_BITS-1 -: 16];
    end else begin : g_hd_narrow
      assign hd16 = {acc_hd, {(16 - ANGLE_BITS){1'b0}}};
    end
  endgenerate

  always_comb begin
    alu_op = odo_pkg::ALU_MUL;
    alu_a  = '0;
    alu_b  = '0;
    unique case (cmd.step)
      odo_pkg::ST_P1:  begin alu_a = odo_pkg::PI_Q24; alu_b = 64'(rad); end
      odo_pkg::ST_DSN: begin alu_a = p1; alu_b = 64'(sum_mag); end
      odo_pkg::ST_DSD: begin alu_a = DsK; alu_b = 64'(cpr_eff); end
      odo_pkg::ST_DSQ: begin alu_op = odo_pkg::ALU_DIV; alu_a = wk; alu_b = den; end
      odo_pkg::ST_CT:  begin alu_a = 64'(trk_eff); alu_b = 64'(cpr_eff); end
      odo_pkg::ST_THN: begin alu_a = p1; alu_b = 64'(dd_mag); end
      odo_pkg::ST_THQ: begin alu_op = odo_pkg::ALU_DIV; alu_a = wk; alu_b = ct << ThrShift; end
      odo_pkg::ST_TBN: begin alu_a = 64'(rad); alu_b = 64'(dd_mag); end
      odo_pkg::ST_TBQ: begin alu_op = odo_pkg::ALU_DIV; alu_a = wk; alu_b = ct << 2; end
      odo_pkg::ST_DXM: begin alu_a = dsc_mag; alu_b = 64'(cos_mag); end
      odo_pkg::ST_DYM: begin alu_a = dsc_mag; alu_b = 64'(sin_mag); end
      odo_pkg::ST_VLM: begin alu_a = ds_mag; alu_b = odo_pkg::MICRO; end
      odo_pkg::ST_VLQ: begin alu_op = odo_pkg::ALU_DIV; alu_a = wk; alu_b = 64'(us_r); end
      odo_pkg::ST_WRM: begin alu_a = dthr_mag; alu_b = odo_pkg::MICRO; end
      odo_pkg::ST_WRQ: begin alu_op = odo_pkg::ALU_DIV; alu_a = wk; alu_b = 64'(us_r); end
      default: ;
    endcase
  end

  assign cor_start      = cmd.go && (cmd.step == odo_pkg::ST_COR);
  assign alu_start      = cmd.go && (cmd.step != odo_pkg::ST_COR);
  assign stat.unit_done = alu_done || cor_done;

  odo_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (alu_start),
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .result (alu_res),
    .done   (alu_done)
  );

  odo_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .angle ({mid, {(32 - ANGLE_BITS){1'b0}}}),
    .cos_q (cor_c),
    .sin_q (cor_s),
    .done  (cor_done)
  );

  // state with reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      cpr        <= 16'd100;
      rad        <= 20'd95000;
      trk        <= 21'd310000;
      last_left  <= '0;
      last_right <= '0;
      acc_x      <= '0;
      acc_y      <= '0;
      acc_hd     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          odo_pkg::CFG_CPR:    cpr <= cfg_data[15:0];
          odo_pkg::CFG_RADIUS: rad <= cfg_data[19:0];
          odo_pkg::CFG_TRACK:  trk <= cfg_data[20:0];
          default: ;
        endcase
      end
      if (cmd.take_in) begin
        last_left  <= left_count;
        last_right <= right_count;
      end
      if (cmd.cap) begin
        unique case (cmd.step)
          odo_pkg::ST_COR: acc_hd <= acc_hd + dthb[ANGLE_BITS-1:0];
          odo_pkg::ST_DXM: acc_x <= pos_step(acc_x, alu_res, ds[63] ^ cos_r[27]);
          odo_pkg::ST_DYM: acc_y <= pos_step(acc_y, alu_res, ds[63] ^ sin_r[27]);
          default: ;
        endcase
      end
    end
  end

  // working registers and result holding
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      sum_r <= 18'(dl) + 18'(dr);
      dd_r  <= 18'(dr) - 18'(dl);
      us_r  <= elapsed_us;
    end
    if (cmd.cap) begin
      unique case (cmd.step)
        odo_pkg::ST_P1:  p1 <= alu_res;
        odo_pkg::ST_DSN: wk <= alu_res;
        odo_pkg::ST_DSD: den <= alu_res;
        odo_pkg::ST_DSQ: ds <= sum_r[17] ? -$signed(alu_res) : $signed(alu_res);
        odo_pkg::ST_CT:  ct <= alu_res;
        odo_pkg::ST_THN: wk <= alu_res;
        odo_pkg::ST_THQ: dthr <= dd_r[17] ? -$signed(alu_res) : $signed(alu_res);
        odo_pkg::ST_TBN: wk <= alu_res << ANGLE_BITS;
        odo_pkg::ST_TBQ: dthb <= dd_r[17] ? -$signed(alu_res) : $signed(alu_res);
        odo_pkg::ST_COR: begin
          cos_r <= cor_c;
          sin_r <= cor_s;
        end
        odo_pkg::ST_VLM: wk <= alu_res;
        odo_pkg::ST_VLQ: lin <= speed(ds, ds_mag, alu_res, us_r);
        odo_pkg::ST_WRM: wk <= alu_res;
        odo_pkg::ST_WRQ: turn <= speed(dthr, dthr_mag, alu_res, us_r);
        default: ;
      endcase
    end
    if (cmd.load_out) begin
      pos_x        <= acc_x;
      pos_y        <= acc_y;
      heading      <= hd16;
      linear_speed <= lin;
      turn_rate    <= turn;
    end
  end

endmodule

### hdl/diff_drive_wheel_odometry.sv
// Top level of the differential-drive odometry block.
// Depends on odo_pkg, the odo interfaces, odo_ctrl and odo_datapath.
//
// sample: one request per encoder reading (left/right absolute counts and the
//   microseconds since the last reading). The first request after reset only
//   latches the counts and returns nothing; every later one returns one result.
// result: pose (x, y, heading) and the linear and turn speeds of that step.
// cfg: register writes (0 counts per rev, 1 wheel radius, 2 track width),
//   always ready; write only while no sample is in flight.
// The work for each sample runs through one shared shift-add multiplier (ten
//   products), the same unit as a bit-per-cycle divider (five quotients)
//   and a 30-step CORDIC.
// A new sample is accepted only after the result of the last one is loaded;
//   a latched-only first sample leaves the block ready for the next one.
// A finished result sits in the output register; the next sample is accepted
// while it waits. If a second result completes before the first is taken, the
// block holds it and accepts no sample until the output register frees.
// Reset clears the pose, the latched counts and the config to defaults.
module diff_drive_wheel_odometry #(
  parameter int POS_FRAC_BITS = 16,
  parameter int ANGLE_BITS    = 16
) (
  input logic         clk,
  input logic         rst,
  odo_sample_if.sink  sample,
  odo_result_if.source result,
  odo_cfg_if.sink     cfg
);

  odo_pkg::dp_cmd_t  cmd;
  odo_pkg::dp_stat_t stat;

  assign cfg.ready = 1'b1;

  odo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  odo_datapath #(
    .POS_FRAC_BITS (POS_FRAC_BITS),
    .ANGLE_BITS    (ANGLE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .left_count   (sample.left_count),
    .right_count  (sample.right_count),
    .elapsed_us   (sample.elapsed_us),
    .pos_x        (result.pos_x),
    .pos_y        (result.pos_y),
    .heading      (result.heading),
    .linear_speed (result.linear_speed),
    .turn_rate    (result.turn_rate)
  );

endmodule

### hdl/odo_checker.sv
// Port-level checks for the odometry block, bound onto the top level.
// Depends only on the top level's ports.
module odo_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pos_x,
  input logic [15:0] heading,
  input logic        cfg_ready
);

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(heading))
    else $error("stalled result changed");

  // a result only appears when the sample port was not ready just before it
  a_rise_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while idle");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port stalled");

endmodule

bind diff_drive_wheel_odometry odo_checker u_odo_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .pos_x     (result.pos_x),
  .heading   (result.heading),
  .cfg_ready (cfg.ready)
);
